[rtl/spt_pkg.sv]
// Package for the sorted periodic timer queue: sizes, request and result
// types, result codes, controller command and status structs, helpers.
// No dependencies; every other file of the block but spt_ram imports it.
package spt_pkg;

  localparam int TIMER_SLOTS  = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int SLOT_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int LIMIT_W = $clog2(RESULT_LIMIT + 1);

  localparam int DEADLINE_W = 48;
  localparam int PERIOD_W   = 32;
  localparam int STAMP_W    = 32;
  localparam int KIND_W     = 2;
  localparam int SLOTF_W    = 4;
  localparam int ENTRY_W    = DEADLINE_W + PERIOD_W + STAMP_W;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

  typedef struct packed {
    logic                  action;
    logic [DEADLINE_W-1:0] deadline_ms;
    logic [PERIOD_W-1:0]   period_ms;
    logic [DEADLINE_W-1:0] now_ms;
  } spt_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOTF_W-1:0] slot;
    logic               last;
  } spt_rsp_t;

  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [PERIOD_W-1:0]   period;
    logic [STAMP_W-1:0]    stamp;
  } spt_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the request and prepare the first pass
    logic add_step;   // test one slot for an add
    logic scan_step;  // issue one table read of a pass
    logic pass_end;   // act on the winner of the pass
    logic tail;       // report the held result as the final one
  } spt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic slot_free;
    logic best_found;
    logic limit_hit;
  } spt_stat_t;

  // Insertion stamps compare modulo 2^32.
  function automatic logic stamp_before(input logic [STAMP_W-1:0] a,
                                        input logic [STAMP_W-1:0] b);
    logic [STAMP_W-1:0] diff;
    diff = a - b;
    return diff[STAMP_W-1];
  endfunction

  // Slot number as reported: the index modulo 16.
  function automatic logic [SLOTF_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOTF_W-1:0] ext;
    ext = (SLOT_W + SLOTF_W)'(idx);
    return ext[SLOTF_W-1:0];
  endfunction

endpackage

[rtl/sorted_periodic_timer_queue.sv]
// Top level of the sorted periodic timer queue.
// Depends on spt_pkg, spt_controller and spt_datapath.
// Usage. A request is presented on req_i and taken at a rising edge where
// start is high and busy is low. An add request stores a deadline and a
// re-arm period in the lowest free slot and answers with kind "added" and
// that slot, or with kind "full" when every slot is in use. A check request
// carries the current time and answers with one "expired" result for every
// due timer, earliest deadline first, ties in insertion order, at most
// RESULT_LIMIT per check; the final result of a request has last set. A
// check that finds nothing due gives no result at all.
// Each result is shown for exactly one cycle, marked by result_valid_o; the
// receiver cannot stall the block and must take it in that cycle.
// Sequence. An add tests the slots in ascending order up to the first free
// one, at most TIMER_SLOTS of them, and its result appears in the cycle after.
// A check makes one pass over the timer RAM per expired timer plus a closing
// pass, one read per cycle; each pass is the scan reads, a flush step and a
// decide step. When the result limit ends the check a tail step replaces the
// closing pass. Each result appears at the end of the pass, or tail step, after
// the one that found it. Reset empties the table and clears the insertion
// counter; RAM words are written before read.
module sorted_periodic_timer_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  spt_pkg::spt_req_t req_i,
  output logic              busy,
  output logic              result_valid_o,
  output spt_pkg::spt_rsp_t rsp_o
);
  import spt_pkg::*;

  spt_cmd_t  cmd;
  spt_stat_t stat;

  // The controller chooses the add or check sequence from the action bit of
  // the request being accepted; everything else of the request is held in
  // the datapath from the capture command onwards.
  spt_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (req_i.action),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // The datapath owns the timer RAM, the valid and reported bits, the scan
  // comparator and the result register that drives the output ports.
  spt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

endmodule

[rtl/spt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spt_datapath.sv]
// Datapath of the timer queue: timer RAM, valid and reported bits, scan
// comparator, re-arm adder, insertion counter and result register.
// Depends on spt_pkg and spt_ram.
module spt_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spt_pkg::spt_req_t req_i,
  input  spt_pkg::spt_cmd_t cmd_i,
  output spt_pkg::spt_stat_t stat_o,
  output logic              result_valid_o,
  output spt_pkg::spt_rsp_t rsp_o
);
  import spt_pkg::*;

  spt_req_t              req_q;
  logic [TIMER_SLOTS-1:0] valid_q;
  logic [TIMER_SLOTS-1:0] done_q;
  logic [STAMP_W-1:0]    counter_q;
  logic [SLOT_W-1:0]     idx_q;
  logic [LIMIT_W-1:0]    count_q;

  logic                  rd_pending_q;
  logic [SLOT_W-1:0]     rd_slot_q;

  logic                  best_found_q;
  logic [SLOT_W-1:0]     best_slot_q;
  spt_entry_t            best_q;

  logic                  pend_valid_q;
  logic [SLOT_W-1:0]     pend_slot_q;

  logic                  rsp_valid_q;
  spt_rsp_t              rsp_q;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  spt_entry_t            ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  spt_entry_t            rd_entry;

  logic                  cand;
  logic                  better;
  logic [DEADLINE_W:0]   rearm_sum;
  logic [DEADLINE_W-1:0] rearm_deadline;
  logic                  idx_last;
  logic                  slot_free;
  logic                  limit_hit;

  assign idx_last  = (idx_q == SLOT_W'(TIMER_SLOTS - 1));
  assign slot_free = !valid_q[idx_q];
  assign limit_hit = (count_q == LIMIT_W'(RESULT_LIMIT - 1));

  assign rd_entry = spt_entry_t'(ram_rdata);

  // A slot takes part when it is live, not yet reported in this check and due.
  assign cand = valid_q[rd_slot_q] && !done_q[rd_slot_q] &&
                (rd_entry.deadline <= req_q.now_ms);

  // Slots arrive in ascending order, so a full tie keeps the held winner.
  always_comb begin
    better = 1'b0;
    if (!best_found_q) begin
      better = 1'b1;
    end else if (rd_entry.deadline != best_q.deadline) begin
      better = rd_entry.deadline < best_q.deadline;
    end else if (rd_entry.stamp != best_q.stamp) begin
      better = stamp_before(rd_entry.stamp, best_q.stamp);
    end
  end

  assign rearm_sum      = {1'b0, req_q.now_ms} + (DEADLINE_W + 1)'(best_q.period);
  assign rearm_deadline = rearm_sum[DEADLINE_W] ? {DEADLINE_W{1'b1}}
                                                : rearm_sum[DEADLINE_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '{deadline: req_q.deadline_ms, period: req_q.period_ms,
                  stamp: counter_q};
    if (cmd_i.add_step) begin
      ram_we = slot_free;
    end else if (cmd_i.pass_end && best_found_q && (best_q.period != '0)) begin
      ram_we    = 1'b1;
      ram_waddr = best_slot_q;
      ram_wdata = '{deadline: rearm_deadline, period: best_q.period, stamp: counter_q};
    end
  end

  spt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_step),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Request payload and the winner's copy carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (rd_pending_q && cand && better) begin
      best_q      <= rd_entry;
      best_slot_q <= rd_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      done_q       <= '0;
      counter_q    <= '0;
      idx_q        <= '0;
      count_q      <= '0;
      rd_pending_q <= 1'b0;
      rd_slot_q    <= '0;
      best_found_q <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      rsp_valid_q  <= 1'b0;
      rd_pending_q <= cmd_i.scan_step;

      if (cmd_i.capture) begin
        idx_q        <= '0;
        done_q       <= '0;
        count_q      <= '0;
        best_found_q <= 1'b0;
        pend_valid_q <= 1'b0;
      end

      if (cmd_i.add_step) begin
        if (slot_free) begin
          valid_q[idx_q] <= 1'b1;
          counter_q      <= counter_q + 1'b1;
          rsp_valid_q    <= 1'b1;
          rsp_q          <= '{kind: KIND_ADDED, slot: slot_field(idx_q), last: 1'b1};
        end else if (idx_last) begin
          rsp_valid_q <= 1'b1;
          rsp_q       <= '{kind: KIND_FULL, slot: '0, last: 1'b1};
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end

      if (cmd_i.scan_step) begin
        rd_slot_q <= idx_q;
        if (!idx_last) begin
          idx_q <= idx_q + 1'b1;
        end
      end

      if (rd_pending_q && cand && better) begin
        best_found_q <= 1'b1;
      end

      if (cmd_i.pass_end) begin
        idx_q        <= '0;
        best_found_q <= 1'b0;
        if (best_found_q) begin
          done_q[best_slot_q] <= 1'b1;
          count_q             <= count_q + 1'b1;
          pend_valid_q        <= 1'b1;
          pend_slot_q         <= best_slot_q;
          if (best_q.period != '0) begin
            counter_q <= counter_q + 1'b1;
          end else begin
            valid_q[best_slot_q] <= 1'b0;
          end
          if (pend_valid_q) begin
            rsp_valid_q <= 1'b1;
            rsp_q <= '{kind: KIND_EXPIRED, slot: slot_field(pend_slot_q), last: 1'b0};
          end
        end else begin
          pend_valid_q <= 1'b0;
          if (pend_valid_q) begin
            rsp_valid_q <= 1'b1;
            rsp_q <= '{kind: KIND_EXPIRED, slot: slot_field(pend_slot_q), last: 1'b1};
          end
        end
      end

      if (cmd_i.tail) begin
        pend_valid_q <= 1'b0;
        rsp_valid_q  <= 1'b1;
        rsp_q <= '{kind: KIND_EXPIRED, slot: slot_field(pend_slot_q), last: 1'b1};
      end
    end
  end

  assign stat_o = '{idx_last: idx_last, slot_free: slot_free,
                    best_found: best_found_q, limit_hit: limit_hit};

  assign result_valid_o = rsp_valid_q;
  assign rsp_o          = rsp_q;

endmodule

[rtl/spt_controller.sv]
// Controller state machine of the timer queue: sequences adds, scan passes
// and the final report. Depends on spt_pkg.
module spt_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               action_i,
  input  spt_pkg::spt_stat_t stat_i,
  output spt_pkg::spt_cmd_t  cmd_o,
  output logic               busy
);
  import spt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_FLUSH,
    S_DECIDE,
    S_TAIL
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   busy_q;
  logic   accept;

  assign accept = start && !busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d = (action_i == ACT_CHECK) ? S_SCAN : S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_step = 1'b1;
        if (stat_i.slot_free || stat_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.pass_end = 1'b1;
        if (!stat_i.best_found) begin
          state_d = S_IDLE;
        end else if (stat_i.limit_hit) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

[bench/spt_checker.sv]
// Checker for the sorted periodic timer queue: watches the request and result
// channels, predicts the results of every accepted request and compares them.
// Depends on spt_pkg only.
module spt_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  spt_pkg::spt_req_t req_i,
  input  logic              result_valid_i,
  input  spt_pkg::spt_rsp_t rsp_i,
  output int                fail_count_o,
  output int                results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import spt_pkg::*;

  // Shadow copy of the timer table.
  logic                  timer_live     [TIMER_SLOTS];
  logic [DEADLINE_W-1:0] timer_deadline [TIMER_SLOTS];
  logic [PERIOD_W-1:0]   timer_period   [TIMER_SLOTS];
  logic [STAMP_W-1:0]    timer_stamp    [TIMER_SLOTS];
  logic [STAMP_W-1:0]    next_stamp;

  spt_rsp_t awaited_rsp [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch, %s", $time, what);
    fail_count_o++;
  endtask

  // Queue order: earlier deadline, then earlier stamp (modulo 2^32), then lower slot.
  function automatic logic runs_earlier(input int a, input int b);
    logic [STAMP_W-1:0] gap;
    if (timer_deadline[a] != timer_deadline[b]) begin
      return timer_deadline[a] < timer_deadline[b];
    end
    if (timer_stamp[a] != timer_stamp[b]) begin
      gap = timer_stamp[a] - timer_stamp[b];
      return gap[STAMP_W-1];
    end
    return a < b;
  endfunction

  task automatic predict_request(input spt_req_t r);
    logic [TIMER_SLOTS-1:0] reported;
    logic [DEADLINE_W:0]    rearm;
    spt_rsp_t               burst [$];
    spt_rsp_t               res;
    int                     free_slot;
    int                     best;
    if (r.action == ACT_ADD) begin
      free_slot = -1;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        if (!timer_live[i] && free_slot < 0) free_slot = i;
      end
      res.last = 1'b1;
      if (free_slot < 0) begin
        res.kind = KIND_FULL;
        res.slot = '0;
      end else begin
        timer_live[free_slot]     = 1'b1;
        timer_deadline[free_slot] = r.deadline_ms;
        timer_period[free_slot]   = r.period_ms;
        timer_stamp[free_slot]    = next_stamp;
        next_stamp                = next_stamp + 1'b1;
        res.kind = KIND_ADDED;
        res.slot = SLOTF_W'(free_slot);
      end
      awaited_rsp.push_back(res);
    end else begin
      reported = '0;
      while (burst.size() < RESULT_LIMIT) begin
        best = -1;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (timer_live[i] && !reported[i] && timer_deadline[i] <= r.now_ms &&
              (best < 0 || runs_earlier(i, best))) best = i;
        end
        if (best < 0) break;
        reported[best] = 1'b1;
        res.kind = KIND_EXPIRED;
        res.slot = SLOTF_W'(best);
        res.last = 1'b0;
        burst.push_back(res);
        if (timer_period[best] != '0) begin
          rearm = {1'b0, r.now_ms} + timer_period[best];
          timer_deadline[best] = rearm[DEADLINE_W] ? '1 : rearm[DEADLINE_W-1:0];
          timer_stamp[best]    = next_stamp;
          next_stamp           = next_stamp + 1'b1;
        end else begin
          timer_live[best] = 1'b0;
        end
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[j]) awaited_rsp.push_back(burst[j]);
    end
  endtask

  task automatic check_result(input spt_rsp_t got);
    spt_rsp_t want;
    if (awaited_rsp.size() == 0) begin
      report_mismatch($sformatf("result kind %0d slot %0d with nothing awaited",
                                got.kind, got.slot));
    end else begin
      want = awaited_rsp.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind got %0d, expected %0d", got.kind, want.kind));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot got %0d, expected %0d", got.slot, want.slot));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0d, expected %0d", got.last, want.last));
    end
  endtask

  // A result and a new request never share an edge for the same request, so
  // the comparison goes first and the prediction second.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_SLOTS; i++) timer_live[i] = 1'b0;
      next_stamp   = '0;
      fail_count_o = 0;
      awaited_rsp.delete();
    end else begin
      if (result_valid_i) check_result(rsp_i);
      if (start_i && !busy_i) predict_request(req_i);
    end
    results_due_o = awaited_rsp.size();
  end

endmodule

[bench/tb_sorted_periodic_timer_queue.sv]
// Testbench top for the sorted periodic timer queue: clock, reset, directed
// and random requests, and the verdict. Depends on spt_pkg, spt_checker and the block.
module tb_sorted_periodic_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spt_pkg::*;

  localparam int RANDOM_ITEMS = 108;
  // Quiet tail: the last requests of the run go in back to back.
  localparam int CALM_ITEMS   = 25;
  // A full check costs at most sixteen passes and a tail step, so the settle
  // time covers any request still in flight once nothing is awaited.
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [DEADLINE_W-1:0] TOP_MS = '1;

  logic     clk;
  logic     rst_n;
  logic     start;
  spt_req_t req;
  logic     busy;
  logic     result_valid;
  spt_rsp_t rsp;
  int       fail_count;
  int       results_due;
  int       cycles;

  sorted_periodic_timer_queue dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .req_i          (req),
    .busy           (busy),
    .result_valid_o (result_valid),
    .rsp_o          (rsp)
  );

  spt_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_valid_i (result_valid),
    .rsp_i          (rsp),
    .fail_count_o   (fail_count),
    .results_due_o  (results_due)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [DEADLINE_W-1:0] any_ms();
    return {16'($urandom), $urandom};
  endfunction

  // The fields that a request does not use are filled at random, so that
  // their bits move as well.
  function automatic spt_req_t add_req(input logic [DEADLINE_W-1:0] due,
                                       input logic [PERIOD_W-1:0]   every);
    spt_req_t r;
    r.action      = ACT_ADD;
    r.deadline_ms = due;
    r.period_ms   = every;
    r.now_ms      = any_ms();
    return r;
  endfunction

  function automatic spt_req_t check_req(input logic [DEADLINE_W-1:0] at_ms);
    spt_req_t r;
    r.action      = ACT_CHECK;
    r.deadline_ms = any_ms();
    r.period_ms   = $urandom;
    r.now_ms      = at_ms;
    return r;
  endfunction

  // Called at a falling edge. The request is held until a rising edge sees
  // busy low; busy is sampled at the falling edge, where it is settled and
  // stays put until the next rising edge. Returns at the falling edge after
  // the request has been taken, with start still high, so that a following
  // request goes straight out without start dropping in between.
  task automatic issue(input spt_req_t r);
    logic taken;
    start <= 1'b1;
    req   <= r;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic rest(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Holds the sender off until every awaited result has come and the block
  // has gone idle; a check that found nothing due leaves no result to wait for.
  task automatic drain();
    start <= 1'b0;
    do begin
      @(negedge clk);
    end while (results_due != 0 || busy);
  endtask

  // Watchdog: the run cannot take longer than this, however the block behaves.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [DEADLINE_W-1:0] clock_ms;
    logic [DEADLINE_W-1:0] due;
    logic [PERIOD_W-1:0]   every;
    spt_req_t              r;
    int                    pick;

    rst_n = 1'b0;
    start = 1'b0;
    req   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A check on the empty table must stay silent.
    issue(check_req('0));

    // Fill all sixteen slots. Three one-shot timers tie at 100 ms and must come
    // out in insertion order; two periodic timers tie at 50 ms, one with the
    // longest possible period and one with the shortest.
    issue(add_req('0, '0));
    issue(add_req(48'd100, '0));
    issue(add_req(48'd100, '0));
    issue(add_req(48'd100, '0));
    issue(add_req(TOP_MS, '0));
    issue(add_req(48'd50, '1));
    issue(add_req(48'd50, 32'd1));
    for (int k = 0; k < 9; k++) begin
      due = (k == 0) ? 48'hAAAA_AAAA_AAAA :
            (k == 1) ? 48'h5555_5555_5555 : 48'(k * 37);
      issue(add_req(due, '0));
    end

    // One more add finds the table full.
    issue(add_req(48'd7, '0));

    // Check at the top of the time range: all sixteen timers expire, which is
    // exactly the result limit. Both periodic timers re-arm and saturate.
    issue(check_req(TOP_MS));

    // Their saturated deadlines are due again, so a second check at the top
    // reports them once more, each only once.
    issue(check_req(TOP_MS));

    // The lowest free slot is handed out again, then expires at time zero.
    issue(add_req('0, '0));
    issue(check_req('0));
    drain();

    // Random part. A model clock moves forward with each check; most adds
    // land shortly ahead of it, so checks keep finding due timers, with the
    // odd far-off deadline, an overdue one, and a flush at the top of the range.
    clock_ms = 48'd1000;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 2) drain();
      if (k < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0) begin
        rest($urandom_range(1, 14));
      end
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          due = clock_ms + $urandom_range(0, 200);
        end else if (pick < 9) begin
          due = any_ms();
        end else begin
          due = clock_ms >> 1;
        end
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
          every = '0;
        end else if (pick < 19) begin
          every = $urandom_range(1, 300);
        end else begin
          every = $urandom;
        end
        r = add_req(due, every);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 150);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          r = check_req(TOP_MS);
        end else if (pick == 1) begin
          r = check_req(any_ms());
        end else begin
          r = check_req(clock_ms);
        end
      end
      issue(r);
    end

    drain();
    rest(SETTLE_CYCLES);

    if (fail_count == 0 && results_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sorted_periodic_timer_queue.f]
rtl/spt_pkg.sv
rtl/spt_ram.sv
rtl/spt_datapath.sv
rtl/spt_controller.sv
rtl/sorted_periodic_timer_queue.sv
bench/spt_checker.sv
bench/tb_sorted_periodic_timer_queue.sv
